// ----- sv/wsdb_pkg.sv -----
// ----------------------------------------------------------------------------
// wsdb_pkg
// Shared sizes, codes, command and status types, and pointer helpers for the
// work-stealing deque bank.
// ----------------------------------------------------------------------------
package wsdb_pkg;

	localparam int NUM_QUEUES  = 8;
	localparam int QUEUE_SLOTS = 16;

	localparam int QIDX_W = $clog2(NUM_QUEUES);
	localparam int PTR_W  = $clog2(QUEUE_SLOTS);
	localparam int CNT_W  = PTR_W;
	localparam int ADDR_W = $clog2(NUM_QUEUES * QUEUE_SLOTS);
	localparam int DATA_W = 32;
	localparam int ACT_W  = 3;
	localparam int SEL_W  = 3;
	localparam int VIC_W  = 3;
	localparam int STAT_W = 2;
	localparam int WRAP_W = ((QIDX_W > SEL_W) ? QIDX_W : SEL_W) + 1;

	typedef enum logic [ACT_W-1:0] {
		ACT_PUSH_REAR  = 3'd0,
		ACT_PUSH_FRONT = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_REAR   = 3'd3,
		ACT_PEEK_FRONT = 3'd4,
		ACT_PEEK_REAR  = 3'd5,
		ACT_STEAL      = 3'd6
	} act_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SNAP,
		S_EXEC,
		S_READ,
		S_OUT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic snap;
		logic exec;
		logic finish;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic rd_issued;
	} sts_t;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [PTR_W-1:0] prev_ptr(input logic [PTR_W-1:0] p);
		return (p == '0) ? PTR_W'(QUEUE_SLOTS - 1) : p - 1'b1;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input logic [QIDX_W-1:0] q,
			input logic [PTR_W-1:0] p);
		return ADDR_W'(ADDR_W'(q) * ADDR_W'(QUEUE_SLOTS)) + ADDR_W'(p);
	endfunction

	// Reduces a selector modulo the number of queues by repeated subtraction.
	function automatic logic [QIDX_W-1:0] wrap_sel(input logic [SEL_W-1:0] s);
		logic [WRAP_W-1:0] v;
		v = WRAP_W'(s);
		for (int i = 0; i < 4; i++) begin
			if (v >= WRAP_W'(NUM_QUEUES)) begin
				v = v - WRAP_W'(NUM_QUEUES);
			end
		end
		return QIDX_W'(v);
	endfunction

endpackage

// ----- sv/wsdb_ctrl.sv -----
// ----------------------------------------------------------------------------
// wsdb_ctrl
// Sequencer for the deque bank: accept, snapshot, execute, read (only when the slot memory is read), deliver.
// ----------------------------------------------------------------------------
module wsdb_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output wsdb_pkg::cmd_t cmd,
	input  wsdb_pkg::sts_t sts
);
	import wsdb_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SNAP;
			end
			S_SNAP: state_d = S_EXEC;
			S_EXEC: state_d = sts.rd_issued ? S_READ : S_OUT;
			S_READ: state_d = S_OUT;
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == S_IDLE);
		out_valid  = (state_q == S_OUT);
		cmd.load   = (state_q == S_IDLE) && in_valid;
		cmd.snap   = (state_q == S_SNAP);
		cmd.exec   = (state_q == S_EXEC);
		cmd.finish = (state_q == S_READ);
	end

endmodule

// ----- sv/wsdb_dp.sv -----
// ----------------------------------------------------------------------------
// wsdb_dp
// Datapath: slot memory, per-queue pointers and counts, victim selection and
// result registers.
// ----------------------------------------------------------------------------
module wsdb_dp (
	input  logic                             clk,
	input  logic                             arst_n,
	input  wsdb_pkg::cmd_t                   cmd,
	output wsdb_pkg::sts_t                   sts,
	input  logic [wsdb_pkg::ACT_W-1:0]       action,
	input  logic [wsdb_pkg::SEL_W-1:0]       queue_sel,
	input  logic signed [wsdb_pkg::DATA_W-1:0] value_in,
	output logic signed [wsdb_pkg::DATA_W-1:0] value_out,
	output logic [wsdb_pkg::STAT_W-1:0]      status,
	output logic [wsdb_pkg::VIC_W-1:0]       victim
);
	import wsdb_pkg::*;

	// Latched request.
	logic [ACT_W-1:0]  act_q;
	logic [QIDX_W-1:0] q_q;
	logic [DATA_W-1:0] val_q;

	// Per-queue state.
	logic [PTR_W-1:0] head_q [NUM_QUEUES];
	logic [PTR_W-1:0] tail_q [NUM_QUEUES];
	logic [CNT_W-1:0] cnt_q  [NUM_QUEUES];

	// Snapshot of the selected queue and the chosen victim.
	logic [PTR_W-1:0]  hq_q;
	logic [PTR_W-1:0]  tq_q;
	logic [CNT_W-1:0]  cq_q;
	logic [QIDX_W-1:0] vic_q;
	logic [QIDX_W-1:0] best;

	// Slot memory.
	logic [DATA_W-1:0] mem_q [NUM_QUEUES*QUEUE_SLOTS];
	logic [DATA_W-1:0] rdata_q;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic [DATA_W-1:0] mem_wdata;

	// Pointer update.
	logic              pw_en;
	logic [QIDX_W-1:0] pw_idx;
	logic              pw_head_en;
	logic              pw_tail_en;
	logic [PTR_W-1:0]  pw_head;
	logic [PTR_W-1:0]  pw_tail;
	logic [CNT_W-1:0]  pw_cnt;

	logic              steal_wr_q;
	logic              steal_wr_d;
	stat_t             stat_d;

	logic [PTR_W-1:0]  vt;
	logic [CNT_W-1:0]  vc;
	logic              q_empty;
	logic              q_full;

	logic [DATA_W-1:0] value_q;
	logic [STAT_W-1:0] status_q;
	logic [VIC_W-1:0]  vic_out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action;
			q_q   <= wrap_sel(queue_sel);
			val_q <= value_in;
		end
	end

	// Largest count wins, lowest index on ties.
	always_comb begin
		best = '0;
		for (int i = 1; i < NUM_QUEUES; i++) begin
			if (cnt_q[i] > cnt_q[best]) best = QIDX_W'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.snap) begin
			hq_q  <= head_q[q_q];
			tq_q  <= tail_q[q_q];
			cq_q  <= cnt_q[q_q];
			vic_q <= best;
		end
	end

	assign vt      = tail_q[vic_q];
	assign vc      = cnt_q[vic_q];
	assign q_empty = (hq_q == tq_q);
	assign q_full  = (hq_q == next_ptr(tq_q));

	always_comb begin
		mem_re     = 1'b0;
		mem_raddr  = '0;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = val_q;
		pw_en      = 1'b0;
		pw_idx     = q_q;
		pw_head_en = 1'b0;
		pw_tail_en = 1'b0;
		pw_head    = hq_q;
		pw_tail    = tq_q;
		pw_cnt     = cq_q;
		stat_d     = STAT_OK;
		steal_wr_d = 1'b0;

		if (cmd.exec) begin
			unique case (act_q)
				ACT_PUSH_REAR: begin
					if (q_full) begin
						stat_d = STAT_FULL;
					end else begin
						mem_we     = 1'b1;
						mem_waddr  = slot_addr(q_q, next_ptr(tq_q));
						pw_en      = 1'b1;
						pw_tail_en = 1'b1;
						pw_tail    = next_ptr(tq_q);
						pw_cnt     = cq_q + 1'b1;
					end
				end
				ACT_PUSH_FRONT: begin
					if (q_full) begin
						stat_d = STAT_FULL;
					end else begin
						mem_we     = 1'b1;
						mem_waddr  = slot_addr(q_q, hq_q);
						pw_en      = 1'b1;
						pw_head_en = 1'b1;
						pw_head    = prev_ptr(hq_q);
						pw_cnt     = cq_q + 1'b1;
					end
				end
				ACT_POP_FRONT: begin
					if (q_empty) begin
						stat_d = STAT_EMPTY;
					end else begin
						mem_re     = 1'b1;
						mem_raddr  = slot_addr(q_q, next_ptr(hq_q));
						pw_en      = 1'b1;
						pw_head_en = 1'b1;
						pw_head    = next_ptr(hq_q);
						pw_cnt     = cq_q - 1'b1;
					end
				end
				ACT_POP_REAR: begin
					if (q_empty) begin
						stat_d = STAT_EMPTY;
					end else begin
						mem_re     = 1'b1;
						mem_raddr  = slot_addr(q_q, tq_q);
						pw_en      = 1'b1;
						pw_tail_en = 1'b1;
						pw_tail    = prev_ptr(tq_q);
						pw_cnt     = cq_q - 1'b1;
					end
				end
				ACT_PEEK_FRONT: begin
					if (q_empty) begin
						stat_d = STAT_EMPTY;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = slot_addr(q_q, next_ptr(hq_q));
					end
				end
				ACT_PEEK_REAR: begin
					if (q_empty) begin
						stat_d = STAT_EMPTY;
					end else begin
						mem_re    = 1'b1;
						mem_raddr = slot_addr(q_q, tq_q);
					end
				end
				ACT_STEAL: begin
					if (vc == '0) begin
						stat_d = STAT_EMPTY;
					end else if (vic_q == q_q) begin
						mem_re    = 1'b1;
						mem_raddr = slot_addr(q_q, tq_q);
					end else if (q_full) begin
						stat_d = STAT_FULL;
					end else begin
						// Take the victim's rear now; the push follows once
						// the slot data is back.
						mem_re     = 1'b1;
						mem_raddr  = slot_addr(vic_q, vt);
						pw_en      = 1'b1;
						pw_idx     = vic_q;
						pw_tail_en = 1'b1;
						pw_tail    = prev_ptr(vt);
						pw_cnt     = vc - 1'b1;
						steal_wr_d = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end else if (cmd.finish && steal_wr_q) begin
			mem_we     = 1'b1;
			mem_waddr  = slot_addr(q_q, next_ptr(tq_q));
			mem_wdata  = rdata_q;
			pw_en      = 1'b1;
			pw_tail_en = 1'b1;
			pw_tail    = next_ptr(tq_q);
			pw_cnt     = cq_q + 1'b1;
		end
	end

	assign sts.rd_issued = mem_re;

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_waddr] <= mem_wdata;
		if (mem_re) rdata_q <= mem_q[mem_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (pw_en) begin
			if (pw_head_en) head_q[pw_idx] <= pw_head;
			if (pw_tail_en) tail_q[pw_idx] <= pw_tail;
			cnt_q[pw_idx] <= pw_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steal_wr_q <= 1'b0;
		end else if (cmd.exec) begin
			steal_wr_q <= steal_wr_d;
		end else if (cmd.finish) begin
			steal_wr_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			value_q   <= '0;
			status_q  <= stat_d;
			vic_out_q <= (act_q == ACT_STEAL) ? VIC_W'(vic_q) : '0;
		end else if (cmd.finish) begin
			value_q <= rdata_q;
		end
	end

	assign value_out = value_q;
	assign status    = status_q;
	assign victim    = vic_out_q;

endmodule

// ----- sv/work_stealing_deque_bank.sv -----
// ----------------------------------------------------------------------------
// work_stealing_deque_bank
// Bank of circular double-ended task queues with push, pop, peek and steal.
// ----------------------------------------------------------------------------
// Each request is one transaction on the input channel and yields exactly one
// transaction on the output channel, after which the next request is taken;
// requests are handled one at a time. After acceptance a request passes
// through the snapshot and execute states and then offers its result when it
// does not read the slot memory (pushes, errors and the unused action code);
// when it does (pops, peeks and steals) a read state comes between, because
// the slot memory has a single read port whose data comes back through a
// register. The result then waits for out_ready, and in_ready rises in the
// cycle after it is taken. The cycle after acceptance snapshots the selected
// queue's pointers and picks the steal victim, the queue with the most
// entries and the lowest index on a tie. Each queue holds at most one entry
// fewer than its slot count. Errors (empty source, full target) leave all
// state untouched and return a zero value. The slot memory is not cleared at
// reset; only live entries are ever read.
// ----------------------------------------------------------------------------
module work_stealing_deque_bank (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [wsdb_pkg::ACT_W-1:0]         action,
	input  logic [wsdb_pkg::SEL_W-1:0]         queue_sel,
	input  logic signed [wsdb_pkg::DATA_W-1:0] value_in,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [wsdb_pkg::DATA_W-1:0] value_out,
	output logic [wsdb_pkg::STAT_W-1:0]        status,
	output logic [wsdb_pkg::VIC_W-1:0]         victim
);
	import wsdb_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// The controller sequences each transaction; it never sees the payload.
	wsdb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the queues and the result registers, which keep the
	// result steady while the output transaction is stalled.
	wsdb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.action    (action),
		.queue_sel (queue_sel),
		.value_in  (value_in),
		.value_out (value_out),
		.status    (status),
		.victim    (victim)
	);

	// One request at a time: the block never offers a result while taking a
	// new request.
	assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input and output both open at once");

	// A result is never offered in the cycle straight after acceptance.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !out_valid)
		else $error("result offered too early");

	// Failed requests carry a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status != STAT_OK)) |-> (value_out == '0))
		else $error("error result with non-zero value");

	// A status code outside the defined set never reaches the port.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK || status == STAT_EMPTY || status == STAT_FULL))
		else $error("undefined status code");

endmodule
